/* design/bmg_pkg.sv */
package bmg_pkg;

	localparam int CFG_W = 5;
	localparam logic [CFG_W-1:0] GRID_RESET = 5'd16;

	localparam logic REG_GRID_ROWS = 1'b0;
	localparam logic REG_GRID_COLS = 1'b1;

	localparam logic [1:0] DIR_N = 2'd0;
	localparam logic [1:0] DIR_E = 2'd1;
	localparam logic [1:0] DIR_S = 2'd2;
	localparam logic [1:0] DIR_W = 2'd3;

	typedef enum logic [1:0] {
		REQ_START = 2'd0,
		REQ_DRAW  = 2'd1,
		REQ_READ  = 2'd2,
		REQ_NOP   = 2'd3
	} req_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLR,
		OP_LOAD_REQ,
		OP_START,
		OP_RD_NBR,
		OP_RD_CUR,
		OP_RD_REQ,
		OP_RD_RES,
		OP_WR_CUR,
		OP_MOVE,
		OP_POP_RD,
		OP_POP_LD,
		OP_SET_DONE,
		OP_OUT_LOAD
	} op_t;

	typedef struct packed {
		op_t        op;
		logic       dir_req;
		logic [1:0] dir;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic nbr_ok;
		logic nbr_visited;
		logic stack_empty;
		logic done;
		logic out_busy;
		req_t req;
	} sts_t;

	function automatic logic [3:0] dir_mask(input logic [1:0] d);
		dir_mask = 4'b0001 << d;
	endfunction

endpackage

/* design/bmg_ctrl.sv */
module bmg_ctrl import bmg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [3:0] {
		S_CLR_RST,
		S_CLR_GO,
		S_IDLE,
		S_DEC,
		S_START,
		S_READ,
		S_DRAW_CHK,
		S_DRAW_WC,
		S_DRAW_MV,
		S_BT_RD,
		S_BT_EV,
		S_POP,
		S_POP_LD,
		S_FIN
	} state_t;

	state_t     state_q, state_d;
	logic [1:0] chk_q, chk_d;

	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d     = state_q;
		chk_d       = chk_q;
		cmd.op      = OP_NONE;
		cmd.dir     = chk_q;
		cmd.dir_req = 1'b1;
		unique case (state_q)
			S_CLR_RST: begin
				cmd.op = OP_CLR;
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_CLR_GO: begin
				cmd.op = OP_CLR;
				if (sts.clr_last) state_d = S_START;
			end
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.op  = OP_LOAD_REQ;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				unique case (sts.req)
					REQ_START: state_d = S_CLR_GO;
					REQ_DRAW: begin
						if (!sts.done && sts.nbr_ok) begin
							cmd.op  = OP_RD_NBR;
							state_d = S_DRAW_CHK;
						end else begin
							state_d = S_FIN;
						end
					end
					REQ_READ: begin
						cmd.op  = OP_RD_REQ;
						state_d = S_READ;
					end
					REQ_NOP: state_d = S_FIN;
				endcase
			end
			S_READ: begin
				cmd.op  = OP_RD_RES;
				state_d = S_FIN;
			end
			S_DRAW_CHK: begin
				if (sts.nbr_visited) begin
					state_d = S_FIN;
				end else begin
					cmd.op  = OP_RD_CUR;
					state_d = S_DRAW_WC;
				end
			end
			S_DRAW_WC: begin
				cmd.op  = OP_WR_CUR;
				state_d = S_DRAW_MV;
			end
			S_DRAW_MV: begin
				cmd.op  = OP_MOVE;
				chk_d   = DIR_N;
				state_d = S_BT_RD;
			end
			S_START: begin
				cmd.op  = OP_START;
				chk_d   = DIR_N;
				state_d = S_BT_RD;
			end
			S_BT_RD: begin
				cmd.dir_req = 1'b0;
				if (sts.nbr_ok) begin
					cmd.op  = OP_RD_NBR;
					state_d = S_BT_EV;
				end else if (chk_q == DIR_W) begin
					state_d = S_POP;
				end else begin
					chk_d = chk_q + 2'd1;
				end
			end
			S_BT_EV: begin
				cmd.dir_req = 1'b0;
				if (!sts.nbr_visited) begin
					state_d = S_FIN;
				end else if (chk_q == DIR_W) begin
					state_d = S_POP;
				end else begin
					chk_d   = chk_q + 2'd1;
					state_d = S_BT_RD;
				end
			end
			S_POP: begin
				if (sts.stack_empty) begin
					cmd.op  = OP_SET_DONE;
					state_d = S_FIN;
				end else begin
					cmd.op  = OP_POP_RD;
					state_d = S_POP_LD;
				end
			end
			S_POP_LD: begin
				cmd.op = OP_POP_LD;
				if (sts.stack_empty) begin
					state_d = S_FIN;
				end else begin
					chk_d   = DIR_N;
					state_d = S_BT_RD;
				end
			end
			S_FIN: begin
				if (!sts.out_busy) begin
					cmd.op  = OP_OUT_LOAD;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_CLR_RST;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR_RST;
			chk_q   <= DIR_N;
		end else begin
			state_q <= state_d;
			chk_q   <= chk_d;
		end
	end

endmodule

/* design/bmg_dpath.sv */
module bmg_dpath import bmg_pkg::*; #(
	parameter int MAX_ROWS    = 16,
	parameter int MAX_COLS    = 16,
	parameter int STACK_DEPTH = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output sts_t             sts,
	input  logic [15:0]      s_tdata,
	input  logic [1:0]       s_tuser,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RUW   = $clog2(MAX_ROWS + 1);
	localparam int CUW   = $clog2(MAX_COLS + 1);
	localparam int AW    = RW + CW;
	localparam int DEPTH = 1 << AW;
	localparam int SIW   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int SCW   = $clog2(STACK_DEPTH + 1);

	logic [CFG_W-1:0] grid_rows_q, grid_cols_q;
	logic [RUW-1:0]   rows_used;
	logic [CUW-1:0]   cols_used;

	logic [RW-1:0]  cur_row_q;
	logic [CW-1:0]  cur_col_q;
	logic [SCW-1:0] count_q;
	logic           done_q;
	logic [AW-1:0]  clr_cnt_q;
	logic           out_valid_q;
	logic [7:0]     out_data_q;

	logic [1:0] req_type_q;
	logic [1:0] req_dir_q;
	logic [3:0] req_row_q;
	logic [3:0] req_col_q;
	logic       moved_q;
	logic [3:0] doors_q;

	logic [3:0]    door_mem [DEPTH];
	logic [3:0]    rdata_q;
	logic          rd_cell0_q;
	logic [AW-1:0] stack_mem [STACK_DEPTH];
	logic [AW-1:0] stk_rdata_q;

	logic [1:0]     dir_sel;
	logic [RUW-1:0] nr_ext;
	logic [CUW-1:0] nc_ext;
	logic           side_ok;
	logic           nbr_ok;
	logic [AW-1:0]  cur_addr, nbr_addr, req_addr;
	logic           req_in_grid;
	logic           stack_room;

	logic          rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [3:0]    wr_data;

	logic           stk_we;
	logic [SIW-1:0] stk_waddr;
	logic [SIW-1:0] stk_raddr;

	always_comb begin
		if (grid_rows_q == '0) rows_used = RUW'(1);
		else if (int'(grid_rows_q) > MAX_ROWS) rows_used = RUW'(MAX_ROWS);
		else rows_used = RUW'(grid_rows_q);
		if (grid_cols_q == '0) cols_used = CUW'(1);
		else if (int'(grid_cols_q) > MAX_COLS) cols_used = CUW'(MAX_COLS);
		else cols_used = CUW'(grid_cols_q);
	end

	assign dir_sel = cmd.dir_req ? req_dir_q : cmd.dir;

	always_comb begin
		nr_ext  = RUW'(cur_row_q);
		nc_ext  = CUW'(cur_col_q);
		side_ok = 1'b1;
		unique case (dir_sel)
			DIR_N: begin
				side_ok = (cur_row_q != '0);
				nr_ext  = RUW'(cur_row_q) - RUW'(1);
			end
			DIR_E: nc_ext = CUW'(cur_col_q) + CUW'(1);
			DIR_S: nr_ext = RUW'(cur_row_q) + RUW'(1);
			DIR_W: begin
				side_ok = (cur_col_q != '0);
				nc_ext  = CUW'(cur_col_q) - CUW'(1);
			end
		endcase
	end

	assign nbr_ok      = side_ok && (nr_ext < rows_used) && (nc_ext < cols_used);
	assign cur_addr    = {cur_row_q, cur_col_q};
	assign nbr_addr    = {nr_ext[RW-1:0], nc_ext[CW-1:0]};
	assign req_addr    = {RW'(req_row_q), CW'(req_col_q)};
	assign req_in_grid = (int'(req_row_q) < int'(rows_used))
		&& (int'(req_col_q) < int'(cols_used));
	assign stack_room  = (count_q < SCW'(STACK_DEPTH));

	// door store ports
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = cur_addr;
		wr_en   = 1'b0;
		wr_addr = cur_addr;
		wr_data = '0;
		unique case (cmd.op)
			OP_CLR: begin
				wr_en   = 1'b1;
				wr_addr = clr_cnt_q;
			end
			OP_RD_NBR: begin
				rd_en   = 1'b1;
				rd_addr = nbr_addr;
			end
			OP_RD_CUR: rd_en = 1'b1;
			OP_RD_REQ: begin
				rd_en   = 1'b1;
				rd_addr = req_addr;
			end
			OP_WR_CUR: begin
				wr_en   = 1'b1;
				wr_data = rdata_q | dir_mask(dir_sel);
			end
			OP_MOVE: begin
				wr_en   = 1'b1;
				wr_addr = nbr_addr;
				wr_data = dir_mask(dir_sel + 2'd2);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) door_mem[wr_addr] <= wr_data;
		if (rd_en) begin
			rdata_q    <= door_mem[rd_addr];
			rd_cell0_q <= (rd_addr == '0);
		end
	end

	// path stack
	assign stk_we    = (cmd.op == OP_START) || ((cmd.op == OP_MOVE) && stack_room);
	assign stk_waddr = (cmd.op == OP_START) ? '0 : count_q[SIW-1:0];
	assign stk_raddr = SIW'(count_q - SCW'(1));

	always_ff @(posedge clk) begin
		if (stk_we) stack_mem[stk_waddr] <= (cmd.op == OP_START) ? '0 : cur_addr;
		if (cmd.op == OP_POP_RD) stk_rdata_q <= stack_mem[stk_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= GRID_RESET;
			grid_cols_q <= GRID_RESET;
			cur_row_q   <= '0;
			cur_col_q   <= '0;
			count_q     <= '0;
			done_q      <= 1'b1;
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_GRID_ROWS: grid_rows_q <= cfg_data;
					REG_GRID_COLS: grid_cols_q <= cfg_data;
				endcase
			end
			out_valid_q <= (cmd.op == OP_OUT_LOAD) || (out_valid_q && !m_tready);
			unique case (cmd.op)
				OP_CLR: clr_cnt_q <= clr_cnt_q + AW'(1);
				OP_START: begin
					cur_row_q <= '0;
					cur_col_q <= '0;
					count_q   <= SCW'(1);
					done_q    <= 1'b0;
				end
				OP_MOVE: begin
					cur_row_q <= nr_ext[RW-1:0];
					cur_col_q <= nc_ext[CW-1:0];
					if (stack_room) count_q <= count_q + SCW'(1);
				end
				OP_POP_RD: count_q <= count_q - SCW'(1);
				OP_POP_LD: begin
					cur_row_q <= stk_rdata_q[AW-1:CW];
					cur_col_q <= stk_rdata_q[CW-1:0];
					if (count_q == '0) done_q <= 1'b1;
				end
				OP_SET_DONE: done_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD_REQ: begin
				req_type_q <= s_tuser;
				req_dir_q  <= s_tdata[1:0];
				req_row_q  <= s_tdata[5:2];
				req_col_q  <= s_tdata[9:6];
				moved_q    <= 1'b0;
				doors_q    <= '0;
			end
			OP_MOVE: moved_q <= 1'b1;
			OP_RD_RES: doors_q <= req_in_grid ? rdata_q : 4'd0;
			OP_OUT_LOAD: out_data_q <= {2'b00, done_q, moved_q, doors_q};
			default: ;
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	assign sts.clr_last    = &clr_cnt_q;
	assign sts.nbr_ok      = nbr_ok;
	assign sts.nbr_visited = (rdata_q != '0) || rd_cell0_q;
	assign sts.stack_empty = (count_q == '0);
	assign sts.done        = done_q;
	assign sts.out_busy    = out_valid_q && !m_tready;
	assign sts.req         = req_t'(req_type_q);

endmodule

/* design/backtracking_maze_generator.sv */
// channel | dir | handshake          | payload
// --------+-----+--------------------+-----------------------------------------
// s       | in  | s_tvalid/s_tready  | s_tuser: req_type; s_tdata: direction,
//         |     |                    |   read_row, read_col
// m       | out | m_tvalid/m_tready  | m_tdata: door_bits, moved, maze_done
// cfg     | in  | cfg_we             | cfg_index, cfg_data (grid_rows, grid_cols)
//
// One request at a time. A draw that moves then scans the neighbors of
// the new cell one direction at a time, popping the path stack while
// backtracking. Reset and every start run a clear sweep of the door
// store, one cell a cycle, with s_tready low.
// The result sits in an output register; a stalled m side holds the next
// result back but not the acceptance of the next beat.
module backtracking_maze_generator import bmg_pkg::*; #(
	parameter int MAX_ROWS    = 16,
	parameter int MAX_COLS    = 16,
	parameter int STACK_DEPTH = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [15:0]      s_tdata,   // direction[1:0], read_row[5:2], read_col[9:6]
	input  logic [1:0]       s_tuser,   // req_type[1:0]
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,   // door_bits[3:0], moved[4], maze_done[5]
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	cmd_t cmd;
	sts_t sts;

	bmg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bmg_dpath #(
		.MAX_ROWS    (MAX_ROWS),
		.MAX_COLS    (MAX_COLS),
		.STACK_DEPTH (STACK_DEPTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

endmodule
